### rtl/gamepad_input_conditioner_unit_defines.svh
// Assertion macros shared by the gamepad input conditioner RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef GAMEPAD_INPUT_CONDITIONER_UNIT_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define GIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the following edge.
`define GIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gic_pkg.sv
// Types, constants and sequencer states of the gamepad input conditioner.
// No dependencies; imported by gamepad_input_conditioner_unit.
package gic_pkg;

    // Poll beat: raw controller state
    typedef struct packed {
        logic [15:0]        buttons;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x_raw;
        logic signed [15:0] left_y_raw;
        logic signed [15:0] right_x_raw;
        logic signed [15:0] right_y_raw;
    } gic_poll_t;

    // Result beat: button masks and Q1.15 stick directions
    typedef struct packed {
        logic [15:0]        pressed_mask;
        logic [15:0]        newly_pressed_mask;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } gic_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_CMP,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } gic_state_t;

    localparam int VBTN_COUNT = 16;
    localparam int LB2_IDX    = 14;
    localparam int RB2_IDX    = 11;

    // Raw button bit behind each virtual button; the trigger-driven ones are empty
    localparam logic [15:0] BUTTON_BITS [VBTN_COUNT] = '{
        16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h1000, 16'h2000, 16'h8000, 16'h4000,
        16'h0020, 16'h0010, 16'h0200, 16'h0000, 16'h0080, 16'h0100, 16'h0000, 16'h0040
    };

    localparam logic [14:0] DEADZONE_RESET = 15'd7865;

    // Datapath widths
    localparam int AX_W   = 30;   // scaled axis magnitude
    localparam int SQ_W   = 62;   // sum of squares, padded to whole bit pairs
    localparam int ROOT_W = 31;   // integer square root
    localparam int ACC_W  = 48;   // shared compare-subtract width
    localparam int QUO_W  = 17;   // output quotient
    localparam int CNT_W  = 5;

    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = QUO_W;

    // Full-scale product 32767 * 32768 and the threshold of the normalized path
    localparam logic [63:0] SCALE_D    = 64'd1073709056;
    localparam logic [60:0] NORM_LIMIT = 61'((SCALE_D * SCALE_D) / 64'd1000000);

    // Small-magnitude path: (2|V| + 32767) / 65534
    localparam logic [ACC_W-1:0] TINY_ROUND = 48'd32767;
    localparam logic [31:0]      TINY_DIV   = 32'd65534;

    localparam logic [QUO_W-1:0] SAT_POS = 17'd32767;
    localparam logic [QUO_W-1:0] SAT_NEG = 17'd32768;

endpackage

### rtl/gamepad_input_conditioner_unit.sv
// Gamepad input conditioner: button map, edge detect, stick deadzone and normalization.
// Depends on gic_pkg and the assertion macro header.
// A centred stick is zeroed in load; a stick that is not centred is squared, summed, compared,
// then divided per axis, with a square root before the divides when normalized.
// Throughput: one poll at a time; the FSM returns to idle as the result is registered.
// Reset clears the previous mask and result valid, sets the deadzone to 7865, idles the FSM.
`include "gamepad_input_conditioner_unit_defines.svh"

module gamepad_input_conditioner_unit
    import gic_pkg::*;
#(
    parameter int NUM_BUTTONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [14:0] cfg_wdata,
    input  logic        poll_valid,
    output logic        poll_stall,
    input  gic_poll_t   poll,
    output logic        result_valid,
    input  logic        result_stall,
    output gic_result_t result
);

    localparam logic [15:0] BTN_MASK = 16'((32'd1 << NUM_BUTTONS) - 32'd1);

    // Control state
    gic_state_t       state_reg, state_next;
    logic             stick_reg, stick_next;
    logic             axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [14:0]      deadzone_reg, deadzone_next;
    logic [15:0]      prev_reg, prev_next;
    logic             result_valid_reg, result_valid_next;

    // Payload and datapath
    gic_poll_t          poll_reg, poll_next;
    logic [15:0]        pressed_reg, pressed_next;
    logic [15:0]        newly_reg, newly_next;
    logic [AX_W-1:0]    ax_reg, ax_next;
    logic [AX_W-1:0]    ay_reg, ay_next;
    logic               xpos_reg, xpos_next;
    logic               ypos_reg, ypos_next;
    logic [2*AX_W-1:0]  mul_reg, mul_next;
    logic [SQ_W-1:0]    s_reg, s_next;
    logic               tiny_reg, tiny_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   dsh_reg, dsh_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic signed [15:0] lx_reg, lx_next;
    logic signed [15:0] ly_reg, ly_next;
    logic signed [15:0] rx_reg, rx_next;
    logic signed [15:0] ry_reg, ry_next;
    gic_result_t        result_reg, result_next;

    // Combinational helpers
    logic [15:0]        pressed_raw;
    logic signed [15:0] cur_x, cur_y;
    logic               centred;
    logic [AX_W-1:0]    mul_in;
    logic [ACC_W-1:0]   unit_a, unit_b, unit_diff;
    logic               unit_ge;
    logic [AX_W-1:0]    ax_sel;
    logic               pos_sel;
    logic [15:0]        out_val;

    // Scaled magnitude: v * 32768 for positive v, |v| * 32767 otherwise
    function automatic logic [AX_W-1:0] scale_mag(input logic signed [15:0] v);
        logic [16:0] neg17;
        logic [30:0] tmp;
        neg17 = 17'd0 - {v[15], v};
        if (v > 16'sd0) begin
            tmp = {1'b0, v[14:0], 15'd0};
        end
        else begin
            tmp = {neg17[15:0], 15'd0} - 31'(neg17[15:0]);
        end
        return tmp[AX_W-1:0];
    endfunction

    // Centred when strictly inside the deadzone on one axis
    function automatic logic in_dz(input logic signed [15:0] v, input logic [14:0] dz);
        logic signed [16:0] v17;
        logic signed [16:0] dz17;
        v17  = {v[15], v};
        dz17 = {2'b00, dz};
        return (v17 < dz17) && (v17 > -dz17);
    endfunction

    // Map raw buttons and triggers to virtual buttons
    always_comb
    begin
        pressed_raw = '0;
        for (int i = 0; i < VBTN_COUNT; i++)
        begin
            pressed_raw[i] = |(poll.buttons & BUTTON_BITS[i]);
        end
        if (poll.left_trigger != 8'd0)
        begin
            pressed_raw[LB2_IDX] = 1'b1;
        end
        if (poll.right_trigger != 8'd0)
        begin
            pressed_raw[RB2_IDX] = 1'b1;
        end
        pressed_raw = pressed_raw & BTN_MASK;
    end

    // Select the stick and axis in work
    assign cur_x   = stick_reg ? poll_reg.right_x_raw : poll_reg.left_x_raw;
    assign cur_y   = stick_reg ? poll_reg.right_y_raw : poll_reg.left_y_raw;
    assign centred = in_dz(cur_x, deadzone_reg) && in_dz(cur_y, deadzone_reg);
    assign mul_in  = (state_reg == ST_SQX) ? ax_reg : ay_reg;
    assign ax_sel  = axis_reg ? ay_reg : ax_reg;
    assign pos_sel = axis_reg ? ypos_reg : xpos_reg;

    // Shared compare-subtract unit for square root and divide steps
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            unit_a = {acc_reg[ACC_W-3:0], s_reg[SQ_W-1:SQ_W-2]};
            unit_b = ACC_W'({root_reg, 2'b01});
        end
        else
        begin
            unit_a = acc_reg;
            unit_b = dsh_reg;
        end
    end

    assign unit_ge   = (unit_a >= unit_b);
    assign unit_diff = unit_a - unit_b;

    // Saturate and sign the quotient
    always_comb
    begin
        if (pos_sel)
        begin
            out_val = (quo_reg > SAT_POS) ? SAT_POS[15:0] : quo_reg[15:0];
        end
        else
        begin
            out_val = (quo_reg > SAT_NEG) ? SAT_NEG[15:0] : 16'd0 - quo_reg[15:0];
        end
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        stick_next        = stick_reg;
        axis_next         = axis_reg;
        cnt_next          = cnt_reg;
        deadzone_next     = cfg_wen ? cfg_wdata : deadzone_reg;
        prev_next         = prev_reg;
        result_valid_next = result_valid_reg && result_stall;
        poll_next         = poll_reg;
        pressed_next      = pressed_reg;
        newly_next        = newly_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        xpos_next         = xpos_reg;
        ypos_next         = ypos_reg;
        mul_next          = mul_reg;
        s_next            = s_reg;
        tiny_next         = tiny_reg;
        root_next         = root_reg;
        acc_next          = acc_reg;
        dsh_next          = dsh_reg;
        quo_next          = quo_reg;
        lx_next           = lx_reg;
        ly_next           = ly_reg;
        rx_next           = rx_reg;
        ry_next           = ry_reg;
        result_next       = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (poll_valid)
                begin
                    poll_next    = poll;
                    pressed_next = pressed_raw;
                    newly_next   = pressed_raw & ~prev_reg;
                    prev_next    = pressed_raw;
                    stick_next   = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (centred)
                begin
                    // Both axes centred: zero this stick and move on
                    if (stick_reg)
                    begin
                        rx_next    = '0;
                        ry_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        lx_next    = '0;
                        ly_next    = '0;
                        stick_next = 1'b1;
                    end
                end
                else
                begin
                    ax_next    = scale_mag(cur_x);
                    ay_next    = scale_mag(cur_y);
                    xpos_next  = (cur_x > 16'sd0);
                    ypos_next  = (cur_y > 16'sd0);
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                mul_next   = mul_in * mul_in;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                s_next     = SQ_W'(mul_reg);
                mul_next   = mul_in * mul_in;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                s_next     = s_reg + SQ_W'(mul_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                tiny_next = (s_reg[SQ_W-2:0] <= NORM_LIMIT);
                axis_next = 1'b0;
                if (s_reg[SQ_W-2:0] <= NORM_LIMIT)
                begin
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    acc_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One root bit per step from the next bit pair
                acc_next  = unit_ge ? unit_diff : unit_a;
                root_next = {root_reg[ROOT_W-2:0], unit_ge};
                s_next    = {s_reg[SQ_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                if (tiny_reg)
                begin
                    acc_next = ACC_W'({ax_sel, 1'b0}) + TINY_ROUND;
                    dsh_next = {TINY_DIV, 16'd0};
                end
                else
                begin
                    acc_next = ACC_W'({ax_sel, 16'd0}) + ACC_W'(root_reg);
                    dsh_next = {root_reg, 1'b0, 16'd0};
                end
                quo_next   = '0;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Restoring divide, one quotient bit per step
                acc_next = unit_ge ? unit_diff : acc_reg;
                quo_next = {quo_reg[QUO_W-2:0], unit_ge};
                dsh_next = {1'b0, dsh_reg[ACC_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                case ({stick_reg, axis_reg})
                    2'b00:   lx_next = out_val;
                    2'b01:   ly_next = out_val;
                    2'b10:   rx_next = out_val;
                    default: ry_next = out_val;
                endcase
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_DIV_INIT;
                end
                else if (!stick_reg)
                begin
                    stick_next = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the beat over once the result register is free
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.pressed_mask       = pressed_reg;
                    result_next.newly_pressed_mask = newly_reg;
                    result_next.left_x             = lx_reg;
                    result_next.left_y             = ly_reg;
                    result_next.right_x            = rx_reg;
                    result_next.right_y            = ry_reg;
                    result_valid_next              = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stick_reg        <= 1'b0;
            axis_reg         <= 1'b0;
            cnt_reg          <= '0;
            deadzone_reg     <= DEADZONE_RESET;
            prev_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stick_reg        <= stick_next;
            axis_reg         <= axis_next;
            cnt_reg          <= cnt_next;
            deadzone_reg     <= deadzone_next;
            prev_reg         <= prev_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        poll_reg    <= poll_next;
        pressed_reg <= pressed_next;
        newly_reg   <= newly_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        xpos_reg    <= xpos_next;
        ypos_reg    <= ypos_next;
        mul_reg     <= mul_next;
        s_reg       <= s_next;
        tiny_reg    <= tiny_next;
        root_reg    <= root_next;
        acc_reg     <= acc_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        lx_reg      <= lx_next;
        ly_reg      <= ly_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        result_reg  <= result_next;
    end

    assign poll_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Normalized quotient never exceeds full scale
    `GIC_ASSERT(a_quo_bound,
                (state_reg == ST_STORE && !tiny_reg) |-> (quo_reg <= SAT_NEG),
                "normalized quotient above full scale")
    // Normalized divide never starts with a zero root
    `GIC_ASSERT(a_root_nonzero,
                (state_reg == ST_DIV_INIT && !tiny_reg) |-> (root_reg != '0),
                "zero divisor in normalized divide")
    // Newly pressed buttons are a subset of pressed ones
    `GIC_ASSERT(a_edge_subset,
                result_valid |-> ((result.newly_pressed_mask & ~result.pressed_mask) == 16'd0),
                "newly pressed outside pressed mask")
    // Buttons beyond the configured count stay clear
    `GIC_ASSERT(a_mask_width,
                result_valid |-> ((result.pressed_mask & ~BTN_MASK) == 16'd0),
                "pressed bit beyond button count")
    // A finished square root always leads into the first divide
    `GIC_ASSERT_NEXT(a_sqrt_to_div,
                     (state_reg == ST_SQRT && cnt_reg == '0),
                     (state_reg == ST_DIV_INIT && !axis_reg),
                     "square root did not hand over to divide")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for gamepad_input_conditioner_unit: a queue-fed driver offers polls,
// a monitor predicts each conditioned report and compares it field by field.
// Depends on gic_pkg for the beat types and on the unit's RTL.

module testbench;
    import gic_pkg::*;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          HOLD_AT_POLL = 400;
    localparam logic [14:0] DZ_AT_RESET  = 15'd7865;
    // Normalize only above one millionth of full scale squared
    localparam logic [63:0] FULL_SCALE   = 64'd32767 * 64'd32768;
    localparam logic [63:0] NORM_FLOOR   = (FULL_SCALE * FULL_SCALE) / 64'd1000000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wen      = 1'b0;
    logic [14:0] cfg_wdata    = '0;
    logic        poll_valid   = 1'b0;
    logic        poll_stall;
    gic_poll_t   poll_beat    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    gic_result_t report_beat;

    gic_poll_t   poll_backlog [$];
    gic_result_t due_reports [$];

    int          issued_polls  = 0;
    int          polls_taken   = 0;
    int          reports_seen  = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;
    logic        poll_took     = 1'b0;
    logic        quiet         = 1'b0;
    logic        hold_on       = 1'b0;
    int          poll_gap      = 0;
    int          poll_idle_pct = 0;
    int          stall_left    = 0;
    int          stall_pct     = 0;

    // Predictor state
    logic [15:0] last_pressed = '0;
    int          dz_shadow    = int'(DZ_AT_RESET);

    // Generator state
    logic [15:0] gen_buttons = '0;
    int          gen_dz      = int'(DZ_AT_RESET);

    gamepad_input_conditioner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .poll_valid   (poll_valid),
        .poll_stall   (poll_stall),
        .poll         (poll_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (report_beat)
    );

    always #5 clk = ~clk;

    // Virtual button order: pad, face, select/start, right shoulder, left shoulder
    function automatic logic [15:0] map_buttons(logic [15:0] raw, logic [7:0] lt,
                                                logic [7:0] rt);
        return {raw[6], |lt, raw[8], raw[7], |rt, raw[9], raw[4], raw[5],
                raw[14], raw[15], raw[13], raw[12], raw[3:0]};
    endfunction

    function automatic longint unsigned axis_scale(int v);
        if (v > 0)
            return longint'(v) * 32768;
        return longint'(-v) * 32767;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 30; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    // Apply the axis sign and saturate to Q1.15
    function automatic logic [15:0] to_q15(int v, longint unsigned m);
        if (v > 0)
            return (m > 32767) ? 16'd32767 : 16'(m);
        if (m > 32768)
            m = 32768;
        return 16'(64'd65536 - m);
    endfunction

    // Returns {x, y} of one stick
    function automatic logic [31:0] steer_stick(logic signed [15:0] x, logic signed [15:0] y,
                                                int dz);
        int              xi;
        int              yi;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned s;
        longint unsigned m;
        longint unsigned qx;
        longint unsigned qy;
        xi = int'(x);
        yi = int'(y);
        if (xi < dz && xi > -dz && yi < dz && yi > -dz)
            return 32'd0;
        ax = axis_scale(xi);
        ay = axis_scale(yi);
        s  = ax * ax + ay * ay;
        if (s > NORM_FLOOR)
        begin
            m  = root_floor(s);
            qx = (ax * 65536 + m) / (2 * m);
            qy = (ay * 65536 + m) / (2 * m);
        end
        else
        begin
            qx = (ax * 2 + 32767) / 65534;
            qy = (ay * 2 + 32767) / 65534;
        end
        return {to_q15(xi, qx), to_q15(yi, qy)};
    endfunction

    function automatic gic_result_t condition_poll(gic_poll_t p, logic [15:0] prev, int dz);
        gic_result_t r;
        r.pressed_mask       = map_buttons(p.buttons, p.left_trigger, p.right_trigger);
        r.newly_pressed_mask = r.pressed_mask & ~prev;
        {r.left_x, r.left_y}   = steer_stick(p.left_x_raw, p.left_y_raw, dz);
        {r.right_x, r.right_y} = steer_stick(p.right_x_raw, p.right_y_raw, dz);
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    function automatic int idle_choice();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [15:0] pick_axis(int dz);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       v = -32768;
                    1:       v = 32767;
                    default: v = -32767;
                endcase
            end
            2, 3:
            begin
                v = dz + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4, 5: v = int'($urandom_range(0, 48)) - 24;
            default: return 16'($urandom);
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [15:0] inside_axis(int dz);
        if (dz < 2)
            return 16'd0;
        return 16'(int'($urandom_range(0, 2 * dz - 2)) - (dz - 1));
    endfunction

    task automatic queue_poll(logic [15:0] b, logic [7:0] lt, logic [7:0] rt,
                              logic [15:0] lx, logic [15:0] ly,
                              logic [15:0] rx, logic [15:0] ry);
        gic_poll_t p;
        p.buttons       = b;
        p.left_trigger  = lt;
        p.right_trigger = rt;
        p.left_x_raw    = lx;
        p.left_y_raw    = ly;
        p.right_x_raw   = rx;
        p.right_y_raw   = ry;
        poll_backlog.push_back(p);
        issued_polls++;
    endtask

    task automatic queue_random(int count);
        logic [15:0] b;
        logic [7:0]  lt;
        logic [7:0]  rt;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        repeat (count)
        begin
            // Mostly held or lightly changed buttons so edges stay interesting
            case ($urandom_range(0, 9))
                0, 1, 2: b = gen_buttons;
                3, 4:    b = gen_buttons ^ (16'd1 << $urandom_range(0, 15));
                5:       b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: b = 16'($urandom);
            endcase
            gen_buttons = b;
            lt = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
            rt = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
            lx = pick_axis(gen_dz);
            ly = pick_axis(gen_dz);
            rx = pick_axis(gen_dz);
            ry = pick_axis(gen_dz);
            if ($urandom_range(0, 3) == 0)
            begin
                lx = inside_axis(gen_dz);
                ly = inside_axis(gen_dz);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                rx = inside_axis(gen_dz);
                ry = inside_axis(gen_dz);
            end
            queue_poll(b, lt, rt, lx, ly, rx, ry);
        end
    endtask

    // Wait until every issued poll has come back as a report
    task automatic settle();
        while (reports_seen != issued_polls)
            @(negedge clk);
    endtask

    task automatic reconfigure(logic [14:0] dz);
        settle();
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= dz;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        gen_dz = int'(dz);
    endtask

    // Poll driver: hold a stalled beat, otherwise advance or idle in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            poll_valid <= 1'b0;
        else if (poll_valid && !poll_took)
        begin
        end
        else if (poll_gap > 0)
        begin
            poll_gap--;
            poll_valid <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                poll_idle_pct = idle_choice();
            if (poll_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= poll_idle_pct))
            begin
                poll_beat  <= poll_backlog.pop_front();
                poll_valid <= 1'b1;
            end
            else
            begin
                poll_valid <= 1'b0;
                if (poll_backlog.size() != 0)
                    poll_gap = $urandom_range(0, 3);
            end
        end
    end

    // Report receiver: random stall bursts plus the long hold-off
    always @(negedge clk)
    begin
        logic burst;
        if ($urandom_range(0, 63) == 0)
            stall_pct = idle_choice();
        if (stall_left > 0)
        begin
            stall_left--;
            burst = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 3);
            burst = 1'b1;
        end
        else
            burst = 1'b0;
        result_stall <= hold_on || burst;
    end

    // Hold off the receiver long enough for the unit to back up its input
    initial
    begin
        while (polls_taken < HOLD_AT_POLL)
            @(negedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES)
            @(negedge clk);
        hold_on <= 1'b0;
    end

    // Monitor: check report beats, predict on poll beats, track the deadzone
    always @(posedge clk)
    begin
        gic_result_t want;
        poll_took <= poll_valid && !poll_stall;
        if (!rst_n)
        begin
            last_pressed = '0;
            dz_shadow    = int'(DZ_AT_RESET);
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                reports_seen <= reports_seen + 1;
                if (due_reports.size() == 0)
                begin
                    $error("report beat with no poll outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("pressed_mask", want.pressed_mask, report_beat.pressed_mask);
                    check_field("newly_pressed_mask", want.newly_pressed_mask,
                                report_beat.newly_pressed_mask);
                    check_field("left_x", want.left_x, report_beat.left_x);
                    check_field("left_y", want.left_y, report_beat.left_y);
                    check_field("right_x", want.right_x, report_beat.right_x);
                    check_field("right_y", want.right_y, report_beat.right_y);
                end
            end
            if (poll_valid && !poll_stall)
            begin
                want = condition_poll(poll_beat, last_pressed, dz_shadow);
                last_pressed = want.pressed_mask;
                due_reports.push_back(want);
                polls_taken <= polls_taken + 1;
            end
            if (cfg_wen)
                dz_shadow = int'(cfg_wdata);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed polls at the reset deadzone
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(0), 16'(0), 16'(0), 16'(0));
        queue_poll(16'hFFFF, 8'd255, 8'd255, 16'(32767), 16'(32767), 16'(-32768), 16'(-32768));
        queue_poll(16'hFFFF, 8'd255, 8'd255, 16'(-32768), 16'(32767), 16'(32767), 16'(-32768));
        queue_poll(16'h0000, 8'd1, 8'd0, 16'(32767), 16'(0), 16'(0), 16'(-32768));
        queue_poll(16'h0000, 8'd0, 8'd1, 16'(7864), 16'(-7864), 16'(7865), 16'(0));
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(-7864), 16'(7864), 16'(-7865), 16'(0));
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(0), 16'(7865), 16'(1), 16'(-1));
        queue_poll(16'h0000, 8'd128, 8'd64, 16'(-1), 16'(-32767), 16'(100), 16'(-7865));
        for (int i = 0; i < 16; i++)
            queue_poll(16'd1 << i, 8'd0, 8'd0, 16'(i * 4111), 16'(-(i * 2011)),
                       16'(7865 - i), 16'(i - 7865));

        // Zero deadzone: a stick at rest goes through the small-magnitude path
        reconfigure(15'd0);
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(0), 16'(0), 16'(0), 16'(0));
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(1), 16'(-1), 16'(32), 16'(-33));
        queue_poll(16'h0000, 8'd0, 8'd0, 16'(0), 16'(-1), 16'(5), 16'(0));
        queue_random(100);

        reconfigure(15'd32767);
        queue_random(60);

        reconfigure(15'd24);
        queue_random(150);

        reconfigure(15'($urandom_range(1, 32766)));
        queue_random(200);

        reconfigure(DZ_AT_RESET);
        queue_random(200);
        settle();
        quiet <= 1'b1;
        queue_random(120);

        settle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/gic_pkg.sv
rtl/gamepad_input_conditioner_unit.sv
test/testbench.sv
